### hw/rtl/bst_pkg.sv
// Shared constants, codes and control structures of the bounded set table.
package bst_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = IDX_W + 1;
   localparam int VAL_W = 32;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;
   localparam logic [1:0] FUNC_LOOKUP = 2'd2;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_MISS    = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   typedef struct packed {
      logic load;
      logic step;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic search_end;
   } dp_sts_type;

   typedef struct packed {
      logic [1:0]       status;
      logic             found;
      logic [IDX_W-1:0] slot;
      logic [CNT_W-1:0] count;
   } rsp_type;

endpackage

### hw/rtl/bst_ctrl.sv
// Controller state machine that sequences search and update of the bounded set table.
module bst_ctrl
   import bst_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       out_free,
   input  dp_sts_type dp_sts,
   output dp_cmd_type dp_cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DECIDE
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      dp_cmd   = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dp_cmd.load = 1'b1;
               state_in    = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (dp_sts.search_end) begin
               state_in = ST_DECIDE;
            end else begin
               dp_cmd.step = 1'b1;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               dp_cmd.commit = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/bst_datapath.sv
// Datapath of the bounded set table: entry store, live count, search index and result logic.
module bst_datapath
   import bst_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  dp_cmd_type              dp_cmd,
   output dp_sts_type              dp_sts,
   input  logic [1:0]              req_func,
   input  logic signed [VAL_W-1:0] req_value,
   input  logic                    csr_wr_en,
   input  logic [CNT_W-1:0]        csr_wr_data,
   output rsp_type                 result
);

   logic [VAL_W-1:0] entries_ff [DEPTH];

   logic [CNT_W-1:0] cap_ff,   cap_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff,   idx_in;
   logic             hit_ff,   hit_in;
   logic [IDX_W-1:0] slot_ff,  slot_in;
   logic [1:0]       func_ff;
   logic [VAL_W-1:0] value_ff;

   logic [IDX_W-1:0] last_idx;
   logic [IDX_W-1:0] rd_addr;
   logic [VAL_W-1:0] rd_data;
   logic             match;
   logic [CNT_W-1:0] cap_eff;
   logic             allocated;
   logic             is_ins;
   logic             is_rem;
   logic             ins_ok;
   logic             rem_ok;

   always_comb begin
      last_idx  = IDX_W'(count_ff - CNT_W'(1));
      rd_addr   = dp_cmd.commit ? last_idx : idx_ff[IDX_W-1:0];
      rd_data   = entries_ff[rd_addr];
      match     = (idx_ff < count_ff) && (rd_data == value_ff);
      cap_eff   = (cap_ff > DEPTH_CNT) ? DEPTH_CNT : cap_ff;
      allocated = (cap_eff != '0);
      is_ins    = (func_ff == FUNC_INSERT);
      is_rem    = (func_ff == FUNC_REMOVE);
      ins_ok    = allocated && is_ins && (count_ff < cap_eff) && !hit_ff;
      rem_ok    = allocated && is_rem && hit_ff;
   end

   assign dp_sts.search_end = hit_ff || (idx_ff >= count_ff);

   always_comb begin
      if (!allocated) begin
         result.status = STATUS_FULL;
      end else if (is_ins) begin
         if (count_ff >= cap_eff) begin
            result.status = STATUS_FULL;
         end else if (hit_ff) begin
            result.status = STATUS_MISS;
         end else begin
            result.status = STATUS_DONE;
         end
      end else begin
         result.status = hit_ff ? STATUS_DONE : STATUS_MISS;
      end
      result.found = allocated && hit_ff;
      if (!allocated) begin
         result.slot = '0;
      end else if (ins_ok) begin
         result.slot = count_ff[IDX_W-1:0];
      end else begin
         result.slot = slot_ff;
      end
      if (ins_ok) begin
         result.count = count_ff + CNT_W'(1);
      end else if (rem_ok) begin
         result.count = count_ff - CNT_W'(1);
      end else begin
         result.count = count_ff;
      end
   end

   always_comb begin
      cap_in   = csr_wr_en ? csr_wr_data : cap_ff;
      idx_in   = idx_ff;
      hit_in   = hit_ff;
      slot_in  = slot_ff;
      count_in = count_ff;
      if (dp_cmd.load) begin
         idx_in  = '0;
         hit_in  = 1'b0;
         slot_in = '0;
      end else if (dp_cmd.step) begin
         if (match) begin
            hit_in  = 1'b1;
            slot_in = idx_ff[IDX_W-1:0];
         end else begin
            idx_in = idx_ff + CNT_W'(1);
         end
      end
      if (dp_cmd.commit) begin
         count_in = result.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RESET;
         count_ff <= '0;
         idx_ff   <= '0;
         hit_ff   <= 1'b0;
         slot_ff  <= '0;
      end else begin
         cap_ff   <= cap_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         hit_ff   <= hit_in;
         slot_ff  <= slot_in;
      end
   end

   // The captured request and the entry store carry no reset.
   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         func_ff  <= req_func;
         value_ff <= req_value;
      end
      if (dp_cmd.commit && ins_ok) begin
         entries_ff[count_ff[IDX_W-1:0]] <= value_ff;
      end else if (dp_cmd.commit && rem_ok) begin
         entries_ff[slot_ff] <= rd_data;
      end
   end

endmodule

### hw/rtl/bounded_set_table.sv
// Top level of the bounded set table: controller, datapath and response register.
//
// The bounded set table keeps up to sixteen distinct 32-bit signed values together with a
// live count. Each request transaction asks for an insert, a remove or a lookup of one
// value and yields exactly one response transaction carrying a status, a found flag, the
// slot index and the count after the operation. A request is taken only while the block
// is idle; it then searches the live entries one per clock cycle through a single read port
// of the entry store, so the time a request occupies the block grows with the live count;
// the search loop over the store sets it, and a stalled response register extends it.
// Removal moves the last live entry into the freed slot, so slot numbers of other
// values can change. A finished response waits in an output register, so the next request
// is accepted while the previous response is still stalled. The capacity register resets
// to sixteen; values above sixteen act as sixteen and zero marks the set as unallocated,
// in which case every request answers full and leaves the contents alone. The capacity
// should be written only while no request is in progress.
module bounded_set_table
   import bst_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_func,
   input  logic signed [VAL_W-1:0] req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_status,
   output logic                    rsp_found,
   output logic [IDX_W-1:0]        rsp_slot,
   output logic [CNT_W-1:0]        rsp_count,
   input  logic                    csr_wr_en,
   input  logic [CNT_W-1:0]        csr_wr_data
);

   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;
   rsp_type    result;
   rsp_type    rsp_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // The response register may be refilled when it is empty or its transaction completes.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   bst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .out_free  (out_free),
      .dp_sts    (dp_sts),
      .dp_cmd    (dp_cmd)
   );

   bst_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .dp_cmd      (dp_cmd),
      .dp_sts      (dp_sts),
      .req_func    (req_func),
      .req_value   (req_value),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .result      (result)
   );

   always_comb begin
      if (dp_cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The response payload is loaded only when a request completes.
   always_ff @(posedge clock) begin
      if (dp_cmd.commit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_ff.status;
   assign rsp_found  = rsp_ff.found;
   assign rsp_slot   = rsp_ff.slot;
   assign rsp_count  = rsp_ff.count;

endmodule
